FILE: hdl/assert_macros.svh
// assertion macros shared by the motor fault protection rtl
// expects a clock aclk and an active-low reset aresetn in the calling scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define MFP_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define MFP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define MFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mfp_pkg.sv
// shared types, constants and helper functions of the motor fault protection block
// no dependencies
`default_nettype none

package mfp_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    localparam int DATA_WIDTH  = 16;
    localparam int MAG_WIDTH   = DATA_WIDTH + 1;
    localparam int MASK_WIDTH  = 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    // low-phase threshold is (phase_loss_current * 13107) >> 15, about 0.4
    localparam int LOW_RATIO_NUM   = 13107;
    localparam int LOW_RATIO_SHIFT = 15;

    localparam logic [MASK_WIDTH-1:0] FLT_OC = 5'b00001;
    localparam logic [MASK_WIDTH-1:0] FLT_UV = 5'b00010;
    localparam logic [MASK_WIDTH-1:0] FLT_OV = 5'b00100;
    localparam logic [MASK_WIDTH-1:0] FLT_OT = 5'b01000;
    localparam logic [MASK_WIDTH-1:0] FLT_PL = 5'b10000;

    localparam logic [2:0] REG_OVER_CURRENT   = 3'd0;
    localparam logic [2:0] REG_UNDER_VOLTAGE  = 3'd1;
    localparam logic [2:0] REG_OVER_VOLTAGE   = 3'd2;
    localparam logic [2:0] REG_OVER_TEMP      = 3'd3;
    localparam logic [2:0] REG_PL_CURRENT     = 3'd4;
    localparam logic [2:0] REG_PL_SPEED       = 3'd5;
    localparam logic [2:0] REG_PL_HOLD_COUNT  = 3'd6;

    localparam logic [DATA_WIDTH-1:0] RST_OVER_CURRENT  = 16'd32768;
    localparam logic [DATA_WIDTH-1:0] RST_UNDER_VOLTAGE = 16'd0;
    localparam logic [DATA_WIDTH-1:0] RST_OVER_VOLTAGE  = 16'd65535;
    localparam logic [DATA_WIDTH-1:0] RST_OVER_TEMP     = 16'd32767;
    localparam logic [DATA_WIDTH-1:0] RST_PL_CURRENT    = 16'd32768;
    localparam logic [DATA_WIDTH-1:0] RST_PL_SPEED      = 16'd32768;
    localparam logic [DATA_WIDTH-1:0] RST_PL_HOLD_COUNT = 16'd65535;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef struct packed {
        logic [DATA_WIDTH-1:0]        over_current_limit;
        logic [DATA_WIDTH-1:0]        under_voltage_limit;
        logic [DATA_WIDTH-1:0]        over_voltage_limit;
        logic signed [DATA_WIDTH-1:0] over_temp_limit;
        logic [DATA_WIDTH-1:0]        phase_loss_current;
        logic [DATA_WIDTH-1:0]        phase_loss_speed;
        logic [DATA_WIDTH-1:0]        phase_loss_hold_count;
    } cfg_t;

    // classified item passed from front to back
    typedef struct packed {
        logic clear;
        logic oc;
        logic uv;
        logic ov;
        logic ot;
        logic cand;
    } entry_t;

    typedef struct packed {
        logic [MASK_WIDTH-1:0]  faults;
        logic [COUNT_WIDTH-1:0] count;
    } back_status_t;

    function automatic logic [MAG_WIDTH-1:0] mag17(input logic [DATA_WIDTH-1:0] v);
        logic [MAG_WIDTH-1:0] ext;
        ext = {v[DATA_WIDTH-1], v};
        return v[DATA_WIDTH-1] ? (MAG_WIDTH'(0) - ext) : ext;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/mfp_cfg_regs.sv
// configuration register file of the motor fault protection block
// depends on mfp_pkg
`default_nettype none

module mfp_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [2:0]                     cfg_index,
    input  wire logic [mfp_pkg::DATA_WIDTH-1:0] cfg_wdata,
    output mfp_pkg::cfg_t                       cfg
);
    import mfp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_OVER_CURRENT:  cfg_next.over_current_limit    = cfg_wdata;
                REG_UNDER_VOLTAGE: cfg_next.under_voltage_limit   = cfg_wdata;
                REG_OVER_VOLTAGE:  cfg_next.over_voltage_limit    = cfg_wdata;
                REG_OVER_TEMP:     cfg_next.over_temp_limit       = cfg_wdata;
                REG_PL_CURRENT:    cfg_next.phase_loss_current    = cfg_wdata;
                REG_PL_SPEED:      cfg_next.phase_loss_speed      = cfg_wdata;
                REG_PL_HOLD_COUNT: cfg_next.phase_loss_hold_count = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.over_current_limit    <= RST_OVER_CURRENT;
            cfg_reg.under_voltage_limit   <= RST_UNDER_VOLTAGE;
            cfg_reg.over_voltage_limit    <= RST_OVER_VOLTAGE;
            cfg_reg.over_temp_limit       <= RST_OVER_TEMP;
            cfg_reg.phase_loss_current    <= RST_PL_CURRENT;
            cfg_reg.phase_loss_speed      <= RST_PL_SPEED;
            cfg_reg.phase_loss_hold_count <= RST_PL_HOLD_COUNT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hdl/mfp_front.sv
// front end: accepts samples and reduces them to fault and phase-loss flags
// depends on mfp_pkg
`default_nettype none

module mfp_front (
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_kind,
    input  wire logic [mfp_pkg::DATA_WIDTH-1:0] s_current_a,
    input  wire logic [mfp_pkg::DATA_WIDTH-1:0] s_current_b,
    input  wire logic [mfp_pkg::DATA_WIDTH-1:0] s_current_c,
    input  wire logic [mfp_pkg::DATA_WIDTH-1:0] s_torque_reference,
    input  wire logic [mfp_pkg::DATA_WIDTH-1:0] s_speed,
    input  wire logic [mfp_pkg::DATA_WIDTH-1:0] s_bus_voltage,
    input  wire logic [mfp_pkg::DATA_WIDTH-1:0] s_temperature,
    input  wire mfp_pkg::cfg_t                  cfg,
    input  wire logic                           q_full,
    output logic                                q_push,
    output mfp_pkg::entry_t                     q_push_data
);
    import mfp_pkg::*;

    logic [MAG_WIDTH-1:0]  ia;
    logic [MAG_WIDTH-1:0]  ib;
    logic [MAG_WIDTH-1:0]  ic;
    logic [MAG_WIDTH-1:0]  iref;
    logic [MAG_WIDTH-1:0]  spd;
    logic [MAG_WIDTH-1:0]  oc_lim;
    logic [MAG_WIDTH-1:0]  pl_cur;
    logic [MAG_WIDTH-1:0]  pl_spd;
    logic [31:0]           thr_prod;
    logic [MAG_WIDTH-1:0]  low_thr;

    assign ia   = mag17(s_current_a);
    assign ib   = mag17(s_current_b);
    assign ic   = mag17(s_current_c);
    assign iref = mag17(s_torque_reference);
    assign spd  = mag17(s_speed);

    assign oc_lim = {1'b0, cfg.over_current_limit};
    assign pl_cur = {1'b0, cfg.phase_loss_current};
    assign pl_spd = {1'b0, cfg.phase_loss_speed};

    assign thr_prod = {16'b0, cfg.phase_loss_current} * 32'(LOW_RATIO_NUM);
    assign low_thr  = MAG_WIDTH'(thr_prod >> LOW_RATIO_SHIFT);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_push_data.clear = (s_kind == KIND_CLEAR);
        q_push_data.oc    = (ia > oc_lim) || (ib > oc_lim) || (ic > oc_lim);
        q_push_data.uv    = s_bus_voltage < cfg.under_voltage_limit;
        q_push_data.ov    = s_bus_voltage > cfg.over_voltage_limit;
        q_push_data.ot    = $signed(s_temperature) > cfg.over_temp_limit;
        q_push_data.cand  = (iref >= pl_cur) && (spd >= pl_spd) &&
                            ((ia < low_thr) || (ib < low_thr) || (ic < low_thr));
    end

endmodule

`default_nettype wire

FILE: hdl/mfp_queue.sv
// short queue of classified items between front and back
// depends on mfp_pkg
`default_nettype none

module mfp_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire mfp_pkg::entry_t push_data,
    output logic                 full,
    input  wire logic            pop,
    output logic                 valid,
    output mfp_pkg::entry_t      data
);
    import mfp_pkg::*;

    entry_t                mem_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg;
    logic [QPTR_WIDTH-1:0] wr_ptr_next;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg;
    logic [QPTR_WIDTH-1:0] rd_ptr_next;
    logic [QCNT_WIDTH-1:0] count_reg;
    logic [QCNT_WIDTH-1:0] count_next;
    logic                  do_push;
    logic                  do_pop;

    function automatic logic [QPTR_WIDTH-1:0] ptr_inc(input logic [QPTR_WIDTH-1:0] p);
        return (p == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = (count_reg == QCNT_WIDTH'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign data    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/mfp_back.sv
// back end: sticky fault latch, phase-loss run counter and output register
// depends on mfp_pkg
`default_nettype none

module mfp_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [mfp_pkg::DATA_WIDTH-1:0] hold_count,
    input  wire logic                           q_valid,
    input  wire mfp_pkg::entry_t                q_data,
    output logic                                q_pop,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [mfp_pkg::MASK_WIDTH-1:0]      m_fault_flags,
    output mfp_pkg::back_status_t               status
);
    import mfp_pkg::*;

    logic [MASK_WIDTH-1:0]  faults_reg;
    logic [MASK_WIDTH-1:0]  faults_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [MASK_WIDTH-1:0]  mask_reg;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [MASK_WIDTH-1:0]  flags_or;
    logic                   pl_hit;

    assign q_pop = q_valid && (!m_valid_reg || m_ready);

    always_comb begin
        count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        pl_hit    = CMP_WIDTH'(count_inc) >= CMP_WIDTH'(hold_count);
        flags_or  = faults_reg
                  | (q_data.oc ? FLT_OC : '0)
                  | (q_data.uv ? FLT_UV : '0)
                  | (q_data.ov ? FLT_OV : '0)
                  | (q_data.ot ? FLT_OT : '0);
        faults_next = faults_reg;
        count_next  = count_reg;
        if (q_pop) begin
            if (q_data.clear) begin
                faults_next = '0;
                count_next  = '0;
            end else if (q_data.cand) begin
                count_next  = count_inc;
                faults_next = flags_or | (pl_hit ? FLT_PL : '0);
            end else begin
                count_next  = '0;
                faults_next = flags_or;
            end
        end
    end

    always_comb begin
        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            faults_reg  <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            faults_reg  <= faults_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            mask_reg <= faults_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_fault_flags = mask_reg;
    assign status.faults = faults_reg;
    assign status.count  = count_reg;

endmodule

`default_nettype wire

FILE: hdl/motor_fault_protection.sv
// motor drive fault protection latch, top level
// depends on mfp_pkg, mfp_cfg_regs, mfp_front, mfp_queue, mfp_back, assert_macros.svh
//
// Input channel s_*: one item per transfer, either a measurement sample (three phase
// currents, torque reference, speed, bus voltage, temperature) or a clear command.
// Output channel m_*: one fault mask per input item, in order.
// Configuration: cfg_wr_en writes cfg_wdata to the register at cfg_index;
// write only while no item is in flight.
// The mask of an item passes through the queue and then the output register before it
// is on m_*; a stall of the receiver holds it back further.
// Throughput: one item per cycle while m_ready is high; the front compares and
// classifies in the transfer cycle, the back updates the fault latch and run counter
// once per item. A two-entry queue separates them; when the receiver stalls the output
// register holds its mask, the queue fills, and s_ready drops once it is full.
// Reset (synchronous, aresetn low): fault latch and run counter zero, queue empty,
// no output valid, limits at their default values.
`default_nettype none

`include "assert_macros.svh"

module motor_fault_protection (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [2:0]                     cfg_index,
    input  wire logic [mfp_pkg::DATA_WIDTH-1:0] cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_kind,
    input  wire logic [mfp_pkg::DATA_WIDTH-1:0] s_current_a,
    input  wire logic [mfp_pkg::DATA_WIDTH-1:0] s_current_b,
    input  wire logic [mfp_pkg::DATA_WIDTH-1:0] s_current_c,
    input  wire logic [mfp_pkg::DATA_WIDTH-1:0] s_torque_reference,
    input  wire logic [mfp_pkg::DATA_WIDTH-1:0] s_speed,
    input  wire logic [mfp_pkg::DATA_WIDTH-1:0] s_bus_voltage,
    input  wire logic [mfp_pkg::DATA_WIDTH-1:0] s_temperature,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [mfp_pkg::MASK_WIDTH-1:0]      m_fault_flags
);
    import mfp_pkg::*;

    cfg_t         cfg;
    logic         q_full;
    logic         q_push;
    entry_t       q_push_data;
    logic         q_pop;
    logic         q_valid;
    entry_t       q_data;
    back_status_t status;

    mfp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mfp_front u_front (
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_current_a        (s_current_a),
        .s_current_b        (s_current_b),
        .s_current_c        (s_current_c),
        .s_torque_reference (s_torque_reference),
        .s_speed            (s_speed),
        .s_bus_voltage      (s_bus_voltage),
        .s_temperature      (s_temperature),
        .cfg                (cfg),
        .q_full             (q_full),
        .q_push             (q_push),
        .q_push_data        (q_push_data)
    );

    mfp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_data)
    );

    mfp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .hold_count    (cfg.phase_loss_hold_count),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_fault_flags (m_fault_flags),
        .status        (status)
    );

    // a clear command answers with an empty mask
    `MFP_ASSERT_NEXT(a_clear_zero, q_pop && q_data.clear, m_fault_flags == '0 && status.count == '0, "clear did not zero faults")
    // faults stay latched across samples
    `MFP_ASSERT_NEXT(a_sticky, q_pop && !q_data.clear, (status.faults & $past(status.faults)) == $past(status.faults), "latched fault lost")
    // a non-candidate sample breaks the phase-loss run
    `MFP_ASSERT_NEXT(a_run_break, q_pop && !q_data.cand, status.count == '0, "run counter not cleared")
    // the output register always mirrors the latch after a transfer out of the queue
    `MFP_ASSERT_NEXT(a_mask_match, q_pop, m_valid && m_fault_flags == status.faults, "mask differs from latch")

endmodule

`default_nettype wire
